// ----- sv/rne_pkg.sv -----
// Shared types, constants and letter tables for the Roman numeral encoder.
package rne_pkg;

    localparam int NUM_W    = 14;
    localparam int CHAR_W   = 7;
    localparam int DIGITS_W = 16;
    localparam int QDEPTH   = 2;

    localparam logic [12:0] RECIP10 = 13'd6554;

    localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
    localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;
    localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
    localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
    localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
    localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
    localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
    localparam logic [CHAR_W-1:0] CH_I    = 7'h49;

    localparam logic [1:0] SH_ONE  = 2'd0;
    localparam logic [1:0] SH_FIVE = 2'd1;
    localparam logic [1:0] SH_TEN  = 2'd2;

    localparam logic [1:0] PL_UNITS     = 2'd0;
    localparam logic [1:0] PL_TENS      = 2'd1;
    localparam logic [1:0] PL_HUNDREDS  = 2'd2;
    localparam logic [1:0] PL_THOUSANDS = 2'd3;

    typedef logic [DIGITS_W-1:0] t_digits;

    typedef struct packed {
        logic    valid;
        t_digits digits;
    } t_push;

    typedef struct packed {
        logic    valid;
        logic    full;
        t_digits digits;
    } t_head;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } t_bstate;

    function automatic logic [2:0] place_len(input logic [3:0] digit, input logic [1:0] place);
        logic [2:0] len;
        len = 3'd0;
        if (place == PL_THOUSANDS) begin
            if (digit inside {[4'd1:4'd3]}) begin
                len = digit[2:0];
            end
        end else begin
            case (digit)
                4'd1, 4'd5:               len = 3'd1;
                4'd2, 4'd4, 4'd6, 4'd9:   len = 3'd2;
                4'd3, 4'd7:               len = 3'd3;
                4'd8:                     len = 3'd4;
                default:                  len = 3'd0;
            endcase
        end
        return len;
    endfunction

    function automatic logic [1:0] shape_code(input logic [3:0] digit, input logic [1:0] idx);
        logic [1:0] code;
        code = SH_ONE;
        case (digit)
            4'd4: begin
                code = (idx == 2'd1) ? SH_FIVE : SH_ONE;
            end
            4'd5, 4'd6, 4'd7, 4'd8: begin
                code = (idx == 2'd0) ? SH_FIVE : SH_ONE;
            end
            4'd9: begin
                code = (idx == 2'd1) ? SH_TEN : SH_ONE;
            end
            default: begin
                code = SH_ONE;
            end
        endcase
        return code;
    endfunction

    function automatic logic [CHAR_W-1:0] place_char(input logic [1:0] place,
                                                     input logic [1:0] code);
        logic [CHAR_W-1:0] ch;
        ch = CH_NONE;
        case (place)
            PL_UNITS: begin
                ch = (code == SH_ONE) ? CH_I : (code == SH_FIVE) ? CH_V : CH_X;
            end
            PL_TENS: begin
                ch = (code == SH_ONE) ? CH_X : (code == SH_FIVE) ? CH_L : CH_C;
            end
            PL_HUNDREDS: begin
                ch = (code == SH_ONE) ? CH_C : (code == SH_FIVE) ? CH_D : CH_M;
            end
            PL_THOUSANDS: begin
                ch = CH_M;
            end
            default: begin
                ch = CH_NONE;
            end
        endcase
        return ch;
    endfunction

endpackage

// ----- sv/rne_front.sv -----
// Front end: accepts a number and splits it into four BCD digits, one digit per cycle.
module rne_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [rne_pkg::NUM_W-1:0] i_number,
    output rne_pkg::t_push           o_push,
    input  logic                     i_full
);
    import rne_pkg::*;

    t_fstate          r_state, n_state;
    logic [NUM_W-1:0] r_val, n_val;
    t_digits          r_digits, n_digits;
    logic [1:0]       r_cnt, n_cnt;

    logic [26:0]      prod;
    logic [10:0]      quot;
    logic [NUM_W-1:0] quot10;
    logic [NUM_W-1:0] diff;

    assign prod   = 27'(r_val) * 27'(RECIP10);
    assign quot   = prod[26:16];
    assign quot10 = 14'({quot, 3'b000}) + 14'({quot, 1'b0});
    assign diff   = r_val - quot10;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (r_cnt == 2'd3) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_comb begin
        n_val         = r_val;
        n_digits      = r_digits;
        n_cnt         = r_cnt;
        o_stall       = (r_state != F_IDLE);
        o_push.valid  = 1'b0;
        o_push.digits = r_digits;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_val = i_number;
                    n_cnt = 2'd0;
                end
            end
            F_DIV: begin
                n_val    = 14'(quot);
                n_digits = {diff[3:0], r_digits[DIGITS_W-1:4]};
                n_cnt    = r_cnt + 2'd1;
            end
            F_PUSH: begin
                o_push.valid = 1'b1;
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_val    <= n_val;
        r_digits <= n_digits;
    end

endmodule

// ----- sv/rne_queue.sv -----
// Two-entry queue of digit sets between the front end and the letter sequencer.
module rne_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rne_pkg::t_push i_push,
    input  logic           i_pop,
    output rne_pkg::t_head o_head
);
    import rne_pkg::*;

    t_digits    r_mem [QDEPTH];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_head.full   = (r_count == 2'(QDEPTH));
    assign o_head.valid  = (r_count != 2'd0);
    assign o_head.digits = r_mem[r_rd];
    assign do_push       = i_push.valid && !o_head.full;
    assign do_pop        = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wr] <= i_push.digits;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue count did not follow a push");

endmodule

// ----- sv/rne_back.sv -----
// Back end: walks the digits and emits one numeral letter per beat.
module rne_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rne_pkg::t_head             i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rne_pkg::CHAR_W-1:0] o_character,
    output logic                       o_last,
    output logic                       o_empty_res
);
    import rne_pkg::*;

    t_bstate           r_state, n_state;
    t_digits           r_digits, n_digits;
    logic [1:0]        r_place, n_place;
    logic [1:0]        r_idx, n_idx;
    logic              r_valid, n_valid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic              r_empty, n_empty;

    logic              out_free;
    logic [3:0]        cur_digit;
    logic [2:0]        cur_len;
    logic              has_letter;
    logic              lower_busy;
    logic              is_last;
    logic              head_empty;

    assign out_free   = !r_valid || !i_stall;
    assign cur_digit  = r_digits[{r_place, 2'b00} +: 4];
    assign cur_len    = place_len(cur_digit, r_place);
    assign has_letter = ({1'b0, r_idx} < cur_len);
    assign is_last    = has_letter && (({1'b0, r_idx} + 3'd1) == cur_len) && !lower_busy;

    always_comb begin
        lower_busy = 1'b0;
        head_empty = 1'b1;
        for (int p = 0; p < 4; p++) begin
            if ((2'(p) < r_place) && (place_len(r_digits[4*p +: 4], 2'(p)) != 3'd0)) begin
                lower_busy = 1'b1;
            end
            if (place_len(i_head.digits[4*p +: 4], 2'(p)) != 3'd0) begin
                head_empty = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_head.valid && out_free && !head_empty) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free && is_last) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        n_digits = r_digits;
        n_place  = r_place;
        n_idx    = r_idx;
        n_valid  = r_valid && i_stall;
        n_char   = r_char;
        n_last   = r_last;
        n_empty  = r_empty;
        o_pop    = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_head.valid && out_free) begin
                    o_pop    = 1'b1;
                    n_digits = i_head.digits;
                    n_place  = PL_THOUSANDS;
                    n_idx    = 2'd0;
                    if (head_empty) begin
                        n_valid = 1'b1;
                        n_char  = CH_NONE;
                        n_last  = 1'b1;
                        n_empty = 1'b1;
                    end
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    if (has_letter) begin
                        n_valid = 1'b1;
                        n_char  = place_char(r_place, shape_code(cur_digit, r_idx));
                        n_last  = is_last;
                        n_empty = 1'b0;
                        if (({1'b0, r_idx} + 3'd1) == cur_len) begin
                            n_place = r_place - 2'd1;
                            n_idx   = 2'd0;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else begin
                        n_place = r_place - 2'd1;
                        n_idx   = 2'd0;
                    end
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_digits <= n_digits;
        r_place  <= n_place;
        r_idx    <= n_idx;
        r_char   <= n_char;
        r_last   <= n_last;
        r_empty  <= n_empty;
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_empty) |-> (r_last && r_char == CH_NONE))
        else $error("empty beat must be a single last beat with no letter");

    a_letter_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_empty) |-> (r_char == CH_M || r_char == CH_D || r_char == CH_C ||
                                   r_char == CH_L || r_char == CH_X || r_char == CH_V ||
                                   r_char == CH_I))
        else $error("letter beat carries an unknown character");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == B_IDLE && i_head.valid))
        else $error("queue popped outside of idle or while empty");

endmodule

// ----- sv/roman_numeral_encoder.sv -----
// Top level of the Roman numeral encoder: digit splitter, queue and letter sequencer.
// Input channel: i_valid, o_stall and i_number carry one number (0 to 9999) per beat.
// Output channel: o_valid, i_stall and o_character, o_last, o_empty_res carry one letter
// per beat, thousands first; o_last marks the final letter of a number.
// A number that yields no letters (0, or a thousands digit above three with nothing
// else) gives a single beat with o_empty_res and o_last set and o_character zero.
// The front end accepts a number when idle, peels off the four decimal digits with a
// reciprocal multiply, then pushes them into a two-entry queue once it has room.
// The back end loads a number from the queue, then emits one letter per cycle while
// the receiver does not stall, stepping over each digit place without letters ahead
// of the final letter; the slower end sets the sustained rate.
// While the receiver stalls, the output beat holds and the sequencer waits; the queue
// keeps accepting until it holds two numbers, the front end then holds one more, and
// the input stays stalled until the queue has room again.
// Reset is synchronous and clears the front end, the queue and the output valid.
module roman_numeral_encoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [rne_pkg::NUM_W-1:0]  i_number,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rne_pkg::CHAR_W-1:0] o_character,
    output logic                       o_last,
    output logic                       o_empty_res
);
    import rne_pkg::*;

    t_push push;
    t_head head;
    logic  pop;

    rne_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_number (i_number),
        .o_push   (push),
        .i_full   (head.full)
    );

    rne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head)
    );

    rne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

endmodule
